@@ rtl/core/adsr_pkg.sv @@
`default_nettype none

package adsr_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int LEVEL_BITS = 16;
	localparam int CFG_DATA_BITS = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
	localparam int CFG_INDEX_BITS = 3;
	localparam int DIV_COUNT_BITS = $clog2(LEVEL_BITS);

	localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 16'hffff;

	// Register reset values and the step values that follow from them.
	localparam logic [LEVEL_BITS-1:0] ATTACK_TIME_RST = 16'h00ff;
	localparam logic [LEVEL_BITS-1:0] DECAY_TIME_RST = 16'h01ff;
	localparam logic [LEVEL_BITS-1:0] SUSTAIN_LEVEL_RST = 16'h7fff;
	localparam logic [LEVEL_BITS-1:0] RELEASE_TIME_RST = 16'h00ff;
	localparam logic [SAMPLE_BITS-1:0] GEN_LOW_RST = '0;
	localparam logic [SAMPLE_BITS-1:0] GEN_HIGH_RST = SAMPLE_BITS'(32'h7fff);
	localparam logic [LEVEL_BITS-1:0] ATTACK_STEP_RST = 16'd257;
	localparam logic [LEVEL_BITS-1:0] DECAY_STEP_RST = 16'd128;
	localparam logic [LEVEL_BITS-1:0] RELEASE_STEP_RST = 16'd257;

	typedef enum logic [2:0] {
		OP_APPLY    = 3'd0,
		OP_GENERATE = 3'd1,
		OP_GATE_ON  = 3'd2,
		OP_GATE_OFF = 3'd3,
		OP_BYPASS   = 3'd4
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ATTACK_TIME   = 3'd0,
		REG_DECAY_TIME    = 3'd1,
		REG_SUSTAIN_LEVEL = 3'd2,
		REG_RELEASE_TIME  = 3'd3,
		REG_GEN_LOW       = 3'd4,
		REG_GEN_HIGH      = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4,
		PH_BYPASS  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		SEL_ATTACK  = 2'd0,
		SEL_DECAY   = 2'd1,
		SEL_RELEASE = 2'd2
	} step_sel_t;

	typedef struct packed {
		logic [2:0]                    op;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          last_in_block;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [LEVEL_BITS-1:0]         level;
		logic                          gate_active;
		logic                          last_out;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/adsr_envelope_generator_top.sv @@
`default_nettype none
// Latency: a sample item's result is valid in the cycle after the item transfer.
// Throughput: one item per cycle when input is not stalled; gate and bypass items give no result.
// A write to a time register queues a bit-serial divide for its step: a load, then
// one step for each of the 16 quotient bits. Item input stalls while divides are
// queued or running.
// Reset: phase idle, level 0, all registers and steps at their default values.

module adsr_envelope_generator_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire adsr_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output adsr_pkg::result_t     result
);
	import adsr_pkg::*;

	localparam int SB = SAMPLE_BITS;

	// Configuration and envelope state
	logic [LEVEL_BITS-1:0]  attack_time_q, decay_time_q, release_time_q, sustain_q;
	logic [SB-1:0]          gen_low_q, gen_high_q;
	logic [LEVEL_BITS-1:0]  attack_step_q, decay_step_q, release_step_q;
	phase_t                 phase_q, phase_d;
	logic [LEVEL_BITS-1:0]  level_q, level_d;

	// Step divider
	logic                      div_busy_q;
	step_sel_t                 div_sel_q;
	logic [DIV_COUNT_BITS-1:0] div_cnt_q;
	logic [LEVEL_BITS-1:0]     div_den_q, div_rem_q, div_quo_q;
	logic [2:0]                pend_q, pend_d, wr_mask, start_mask;
	logic                      div_start;
	step_sel_t                 start_sel;
	logic [LEVEL_BITS-1:0]     start_den;
	logic [LEVEL_BITS:0]       div_trial;
	logic                      div_bit;
	logic [LEVEL_BITS-1:0]     div_rem_d, div_quo_d, div_result;
	logic                      div_done;

	// Datapath
	logic                   item_fire, result_take, res_load;
	logic [LEVEL_BITS:0]    attack_sum;
	logic [LEVEL_BITS-1:0]  lvl1, lvl2, adv_lvl, decay_dif;
	phase_t                 ph1, ph2, adv_ph;
	logic [7:0]             lv;
	logic signed [SB+8:0]   smp_w, lv_w, prod_a;
	logic signed [SB+9:0]   diff_w, lvg_w, prod_g;
	result_t                res_d, result_q;
	logic                   result_valid_q;

	assign item_fire = item_valid && !item_stall;
	assign result_take = result_valid_q && !result_stall;
	assign item_stall = div_busy_q || (|pend_q) || cfg_we || (result_valid_q && result_stall);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_time_q <= ATTACK_TIME_RST;
			decay_time_q <= DECAY_TIME_RST;
			sustain_q <= SUSTAIN_LEVEL_RST;
			release_time_q <= RELEASE_TIME_RST;
			gen_low_q <= GEN_LOW_RST;
			gen_high_q <= GEN_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ATTACK_TIME: attack_time_q <= cfg_data[LEVEL_BITS-1:0];
				REG_DECAY_TIME: decay_time_q <= cfg_data[LEVEL_BITS-1:0];
				REG_SUSTAIN_LEVEL: sustain_q <= cfg_data[LEVEL_BITS-1:0];
				REG_RELEASE_TIME: release_time_q <= cfg_data[LEVEL_BITS-1:0];
				REG_GEN_LOW: gen_low_q <= cfg_data[SB-1:0];
				REG_GEN_HIGH: gen_high_q <= cfg_data[SB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		wr_mask = 3'b000;
		if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ATTACK_TIME: wr_mask[SEL_ATTACK] = 1'b1;
				REG_DECAY_TIME: wr_mask[SEL_DECAY] = 1'b1;
				REG_RELEASE_TIME: wr_mask[SEL_RELEASE] = 1'b1;
				default: ;
			endcase
		end
	end

	// The divider takes the lowest pending step; a write that lands during its
	// own divide marks it pending again, so the newest time always wins.
	always_comb begin
		start_sel = SEL_ATTACK;
		start_den = attack_time_q;
		start_mask = 3'b000;
		if (pend_q[SEL_ATTACK]) begin
			start_sel = SEL_ATTACK;
			start_den = attack_time_q;
			start_mask[SEL_ATTACK] = 1'b1;
		end else if (pend_q[SEL_DECAY]) begin
			start_sel = SEL_DECAY;
			start_den = decay_time_q;
			start_mask[SEL_DECAY] = 1'b1;
		end else if (pend_q[SEL_RELEASE]) begin
			start_sel = SEL_RELEASE;
			start_den = release_time_q;
			start_mask[SEL_RELEASE] = 1'b1;
		end
		div_start = !div_busy_q && (|pend_q);
		pend_d = (pend_q & ~(div_start ? start_mask : 3'b000)) | wr_mask;
	end

	// Restoring division of 0xffff: every dividend bit shifted in is a one.
	assign div_trial = {div_rem_q, 1'b1};
	assign div_bit = (div_trial >= {1'b0, div_den_q});
	assign div_rem_d = div_bit ? LEVEL_BITS'(div_trial - {1'b0, div_den_q})
		: div_trial[LEVEL_BITS-1:0];
	assign div_quo_d = {div_quo_q[LEVEL_BITS-2:0], div_bit};
	assign div_done = div_busy_q && (div_cnt_q == DIV_COUNT_BITS'(LEVEL_BITS - 1));
	assign div_result = (div_den_q == '0) ? '0 : div_quo_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'b000;
			div_busy_q <= 1'b0;
			div_sel_q <= SEL_ATTACK;
			div_cnt_q <= '0;
			attack_step_q <= ATTACK_STEP_RST;
			decay_step_q <= DECAY_STEP_RST;
			release_step_q <= RELEASE_STEP_RST;
		end else begin
			pend_q <= pend_d;
			if (div_start) begin
				div_busy_q <= 1'b1;
				div_sel_q <= start_sel;
				div_cnt_q <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_done) begin
					div_busy_q <= 1'b0;
					case (div_sel_q)
						SEL_ATTACK: attack_step_q <= div_result;
						SEL_DECAY: decay_step_q <= div_result;
						SEL_RELEASE: release_step_q <= div_result;
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_den_q <= start_den;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_rem_q <= div_rem_d;
			div_quo_q <= div_quo_d;
		end
	end

	// One sample's level advance: attack, then decay, then release.
	always_comb begin
		attack_sum = {1'b0, level_q} + {1'b0, attack_step_q};
		lvl1 = level_q;
		ph1 = phase_q;
		if (phase_q == PH_ATTACK) begin
			if (attack_step_q == '0 || attack_sum >= {1'b0, LEVEL_FULL}) begin
				lvl1 = LEVEL_FULL;
				ph1 = PH_DECAY;
			end else begin
				lvl1 = attack_sum[LEVEL_BITS-1:0];
			end
		end

		decay_dif = lvl1 - decay_step_q;
		lvl2 = lvl1;
		ph2 = ph1;
		if (ph1 == PH_DECAY) begin
			if (decay_step_q == '0 || decay_step_q >= lvl1 || decay_dif <= sustain_q) begin
				lvl2 = sustain_q;
				ph2 = PH_SUSTAIN;
			end else begin
				lvl2 = decay_dif;
			end
		end

		adv_lvl = lvl2;
		adv_ph = ph2;
		if (ph2 == PH_RELEASE) begin
			if (release_step_q == '0 || lvl2 <= release_step_q) begin
				adv_lvl = '0;
				adv_ph = PH_IDLE;
			end else begin
				adv_lvl = lvl2 - release_step_q;
			end
		end
	end

	// Next phase and level
	always_comb begin
		phase_d = phase_q;
		level_d = level_q;
		res_load = 1'b0;
		case (op_t'(item.op))
			OP_APPLY, OP_GENERATE: begin
				res_load = 1'b1;
				if (phase_q != PH_BYPASS) begin
					phase_d = adv_ph;
					level_d = adv_lvl;
				end
			end
			OP_GATE_ON: phase_d = PH_ATTACK;
			OP_GATE_OFF: begin
				if (!(phase_q inside {PH_IDLE, PH_BYPASS})) begin
					phase_d = PH_RELEASE;
				end
			end
			OP_BYPASS: phase_d = PH_BYPASS;
			default: ;
		endcase
	end

	// Result: scale by the level's top byte, floor toward minus infinity; bypass is unscaled.
	assign lv = adv_lvl[LEVEL_BITS-1:LEVEL_BITS-8];
	assign smp_w = {{9{item.sample_in[SB-1]}}, item.sample_in};
	assign lv_w = {{(SB+1){1'b0}}, lv};
	assign prod_a = smp_w * lv_w;
	assign diff_w = {{10{gen_high_q[SB-1]}}, gen_high_q} - {{10{gen_low_q[SB-1]}}, gen_low_q};
	assign lvg_w = {{(SB+2){1'b0}}, lv};
	assign prod_g = diff_w * lvg_w;

	always_comb begin
		res_d.last_out = item.last_in_block;
		if (phase_q == PH_BYPASS) begin
			res_d.sample_out = item.sample_in;
			res_d.level = level_q;
			res_d.gate_active = 1'b0;
		end else begin
			if (op_t'(item.op) == OP_GENERATE) begin
				res_d.sample_out = gen_low_q + prod_g[SB+7:8];
			end else begin
				res_d.sample_out = prod_a[SB+7:8];
			end
			res_d.level = adv_lvl;
			res_d.gate_active = (adv_ph inside {PH_ATTACK, PH_DECAY, PH_SUSTAIN});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			level_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_fire) begin
				phase_q <= phase_d;
				level_q <= level_d;
			end
			if (item_fire && res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_take) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire && res_load) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTH
	// Idle is reached only from reset or the end of release, both at level zero.
	a_idle_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (level_q == '0))
		else $error("idle phase with nonzero level");

	a_no_item_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		(div_busy_q || (|pend_q)) |-> !item_fire)
		else $error("item transfer while a step is being computed");

	a_gate_only_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && !res_load && !result_take) |=> (result_valid_q == $past(result_valid_q)))
		else $error("gate item changed the result register");
`endif

endmodule

`default_nettype wire
